### src/md5cdc_pkg.sv
`default_nettype none

package md5cdc_pkg;

   // Steps 0 to 62 are registered, one step per stage; step 63 is folded into the compare
   localparam int PIPE_STAGES = 63;

   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_A           = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_B_UNROTATED = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_C           = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_D           = 8'd3;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5cdc_state_type;

   // Only the words that may be non-zero travel with an item
   typedef struct packed {
      logic [31:0] w14;
      logic [31:0] w4;
      logic [31:0] w3;
      logic [31:0] w2;
      logic [31:0] w1;
      logic [31:0] w0;
   } md5cdc_msg_type;

   function automatic logic [31:0] step_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] step_shift(input logic [3:0] sel);
      logic [4:0] s;
      case (sel)
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] wide;
      wide = {v, v} << s;
      return wide[63:32];
   endfunction

   // Words other than 0..4 and 14 are zero in a single-block candidate
   function automatic logic [31:0] msg_word(input logic [3:0] g, input md5cdc_msg_type m);
      logic [31:0] w;
      case (g)
         4'd0:    w = m.w0;
         4'd1:    w = m.w1;
         4'd2:    w = m.w2;
         4'd3:    w = m.w3;
         4'd4:    w = m.w4;
         4'd14:   w = m.w14;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] round_i(input logic [31:0] b, input logic [31:0] c,
                                           input logic [31:0] d);
      return c ^ (b | ~d);
   endfunction

   function automatic md5cdc_state_type md5_step(input logic [5:0] i,
                                                 input md5cdc_state_type s,
                                                 input md5cdc_msg_type m);
      logic [31:0]      f;
      logic [3:0]       g;
      logic [31:0]      sum;
      md5cdc_state_type r;
      case (i[5:4])
         2'd0: begin
            f = (s.b & s.c) | (~s.b & s.d);
            g = i[3:0];
         end
         2'd1: begin
            f = (s.b & s.d) | (s.c & ~s.d);
            g = 4'(5 * int'(i) + 1);
         end
         2'd2: begin
            f = s.b ^ s.c ^ s.d;
            g = 4'(3 * int'(i) + 5);
         end
         default: begin
            f = round_i(s.b, s.c, s.d);
            g = 4'(7 * int'(i));
         end
      endcase
      sum = s.a + f + step_const(i) + msg_word(g, m);
      r.a = s.d;
      r.b = s.b + rotl32(sum, step_shift({i[5:4], i[1:0]}));
      r.c = s.b;
      r.d = s.c;
      return r;
   endfunction

endpackage

`default_nettype wire

### src/md5cdc_pipe.sv
`default_nettype none

module md5cdc_pipe (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire md5cdc_pkg::md5cdc_msg_type   in_msg,
   output logic                              out_valid,
   output md5cdc_pkg::md5cdc_state_type      out_state
);

   localparam md5cdc_pkg::md5cdc_state_type IV = '{
      a: md5cdc_pkg::IV_A, b: md5cdc_pkg::IV_B,
      c: md5cdc_pkg::IV_C, d: md5cdc_pkg::IV_D
   };

   logic [md5cdc_pkg::PIPE_STAGES-1:0] valid_ff;
   md5cdc_pkg::md5cdc_state_type       state_ff [md5cdc_pkg::PIPE_STAGES];
   md5cdc_pkg::md5cdc_state_type       state_in [md5cdc_pkg::PIPE_STAGES];
   md5cdc_pkg::md5cdc_msg_type         msg_ff   [md5cdc_pkg::PIPE_STAGES];

   // Shift valid bits along with the data; hold everything while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[md5cdc_pkg::PIPE_STAGES-2:0], in_valid};
      end
   end

   for (genvar j = 0; j < md5cdc_pkg::PIPE_STAGES; j++) begin : g_stage
      md5cdc_pkg::md5cdc_state_type src;
      md5cdc_pkg::md5cdc_msg_type   msrc;

      if (j == 0) begin : g_first
         assign src  = IV;
         assign msrc = in_msg;
      end else begin : g_next
         assign src  = state_ff[j-1];
         assign msrc = msg_ff[j-1];
      end

      assign state_in[j] = md5cdc_pkg::md5_step(6'(j), src, msrc);

      always_ff @(posedge clock) begin
         if (advance) begin
            state_ff[j] <= state_in[j];
            msg_ff[j]   <= msrc;
         end
      end
   end

   assign out_valid = valid_ff[md5cdc_pkg::PIPE_STAGES-1];
   assign out_state = state_ff[md5cdc_pkg::PIPE_STAGES-1];

`ifndef SYNTHESIS
   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && advance |=> valid_ff[0])
      else $error("accepted item did not enter the first stage");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("valid bits moved while the pipeline was stalled");
   a_bubble: assert property (@(posedge clock) disable iff (reset)
      advance && !in_valid |=> !valid_ff[0])
      else $error("empty slot did not enter the first stage");
`endif

endmodule

`default_nettype wire

### src/md5_candidate_digest_compare.sv
`default_nettype none

// MD5 candidate check against a prepared target digest.
// req_* carries one single-block candidate (message words 0..4 and word 14);
// rsp_* returns one match flag per request, in request order.
// csr_* writes the four target words (index 0 target_a, 1 target_b_unrotated,
// 2 target_c, 3 target_d; other indexes are ignored). csr_ready is always high;
// write targets only while no request is in flight.
// Path: the accepting edge loads the first of 63 pipeline stages, one MD5 step
// each; a result register after them takes the partial last step and the four
// compares and drives rsp_tvalid.
// Throughput: one request per cycle when not stalled, one MD5 step per stage.
// Stall: while rsp_tvalid waits on rsp_tready, the pipeline keeps moving and
// taking requests until the item in its last stage needs the result register;
// then req_tready drops and every stage holds.
// Reset: clears all valid bits and the targets to zero; items in flight drop.
module md5_candidate_digest_compare (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // msg_word0 [31:0], msg_word1 [63:32], msg_word2 [95:64],
   // msg_word3 [127:96], msg_word4 [159:128], bit_length_word [191:160]
   input  wire logic [191:0]                            req_tdata,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // match [0], zero fill [7:1]
   output logic [7:0]                                   rsp_tdata,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [md5cdc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [31:0]                             csr_data
);

   logic [31:0] target_a_ff;
   logic [31:0] target_b_ff;
   logic [31:0] target_c_ff;
   logic [31:0] target_d_ff;

   logic        rsp_valid_ff;
   logic        rsp_match_ff;
   logic        match_in;
   logic        advance;
   logic        rsp_free;
   logic        last_valid;
   logic [31:0] partial;

   md5cdc_pkg::md5cdc_msg_type   req_msg;
   md5cdc_pkg::md5cdc_state_type last_state;

   assign csr_ready = 1'b1;

   // Decode target writes; drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         target_a_ff <= '0;
         target_b_ff <= '0;
         target_c_ff <= '0;
         target_d_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            md5cdc_pkg::REG_TARGET_A:           target_a_ff <= csr_data;
            md5cdc_pkg::REG_TARGET_B_UNROTATED: target_b_ff <= csr_data;
            md5cdc_pkg::REG_TARGET_C:           target_c_ff <= csr_data;
            md5cdc_pkg::REG_TARGET_D:           target_d_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_msg.w0  = req_tdata[31:0];
   assign req_msg.w1  = req_tdata[63:32];
   assign req_msg.w2  = req_tdata[95:64];
   assign req_msg.w3  = req_tdata[127:96];
   assign req_msg.w4  = req_tdata[159:128];
   assign req_msg.w14 = req_tdata[191:160];

   // Result register can load when empty or being drained this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // Advance unless the last stage holds an item with nowhere to go
   assign advance    = !last_valid || rsp_free;
   assign req_tready = advance;

   md5cdc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_msg    (req_msg),
      .out_valid (last_valid),
      .out_state (last_state)
   );

   // After step 63 (index 62): d holds step 61's value, c step 62's, b step 63's.
   // Step 64 stops at a + I(b, c, d).
   assign partial  = last_state.a +
                     md5cdc_pkg::round_i(last_state.b, last_state.c, last_state.d);
   assign match_in = (last_state.d == target_a_ff) && (last_state.c == target_d_ff) &&
                     (last_state.b == target_c_ff) && (partial == target_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_match_ff <= match_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_match_ff};

`ifndef SYNTHESIS
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && last_valid |-> !req_tready)
      else $error("request taken while the full pipeline was blocked");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
   a_load: assert property (@(posedge clock) disable iff (reset)
      last_valid && rsp_free |=> rsp_tvalid)
      else $error("finished item not moved into the result register");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int IDX_W = md5cdc_pkg::CSR_INDEX_WIDTH;

   // Round constants and per-step rotation amounts of MD5
   localparam logic [31:0] STEP_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };
   localparam int ROT_AMOUNT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

   // Idle tail after the final drain; allow a couple of passes through the pipeline
   localparam int TAIL_CYCLES = 128;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 144;

   // Working words the block compares against the four targets
   typedef struct packed {
      logic [31:0] a61;
      logic [31:0] d62;
      logic [31:0] c63;
      logic [31:0] b_pre;
   } probe_words_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   // msg_word0 [31:0], msg_word1 [63:32], msg_word2 [95:64],
   // msg_word3 [127:96], msg_word4 [159:128], bit_length_word [191:160]
   logic [191:0]                       req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   // match [0], zero fill [7:1]
   logic [7:0]                         rsp_tdata;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [IDX_W-1:0]                   csr_index;
   logic [31:0]                        csr_data;

   // Shadow copy of the target registers, updated on each accepted write
   logic [31:0] tgt_a;
   logic [31:0] tgt_b_pre;
   logic [31:0] tgt_c;
   logic [31:0] tgt_d;

   // Expected match flags, oldest request first
   bit          pending_match [$];
   int          fail_count;
   int          cycle_count;
   int          send_idle_pct;
   int          rsp_stall_pct;

   md5_candidate_digest_compare u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run the first 63 steps on the sparse block, keeping the words that the
   // compare stage looks at; step 64 stops right after its round function.
   function automatic probe_words_type md5_probe(input md5cdc_pkg::md5cdc_msg_type m);
      logic [31:0]     w [16];
      logic [31:0]     a, b, c, d, f, t, sum;
      int              g, s;
      probe_words_type p;
      for (int k = 0; k < 16; k++) w[k] = 32'h0;
      w[0]  = m.w0;
      w[1]  = m.w1;
      w[2]  = m.w2;
      w[3]  = m.w3;
      w[4]  = m.w4;
      w[14] = m.w14;
      a = md5cdc_pkg::IV_A;
      b = md5cdc_pkg::IV_B;
      c = md5cdc_pkg::IV_C;
      d = md5cdc_pkg::IV_D;
      p = '0;
      for (int i = 0; i < 63; i++) begin
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = i % 16;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         sum = a + f + STEP_K[i] + w[g];
         s = ROT_AMOUNT[(i / 16) * 4 + i % 4];
         t = d;
         d = c;
         c = b;
         b = b + ((sum << s) | (sum >> (32 - s)));
         a = t;
         if (i == 60) p.a61 = b;
         if (i == 61) p.d62 = b;
         if (i == 62) p.c63 = b;
      end
      p.b_pre = a + (c ^ (b | ~d));
      return p;
   endfunction

   function automatic bit predict_match(input logic [191:0] payload);
      md5cdc_pkg::md5cdc_msg_type m;
      probe_words_type            p;
      m = payload;
      p = md5_probe(m);
      return (p.a61 == tgt_a) && (p.d62 == tgt_d) && (p.c63 == tgt_c) &&
             (p.b_pre == tgt_b_pre);
   endfunction

   // Digest word k as the little-endian word of digest bytes 4k..4k+3
   function automatic logic [31:0] digest_word(input logic [127:0] dg, input int k);
      logic [31:0] be;
      be = dg[127 - 32 * k -: 32];
      return {be[7:0], be[15:8], be[23:16], be[31:24]};
   endfunction

   function automatic md5cdc_pkg::md5cdc_msg_type rand_candidate();
      md5cdc_pkg::md5cdc_msg_type m;
      m.w0  = $urandom;
      m.w1  = $urandom;
      m.w2  = $urandom;
      m.w3  = $urandom;
      m.w4  = $urandom;
      m.w14 = $urandom;
      // Mostly raw patterns, some shaped like real padded candidates
      if ($urandom_range(0, 3) == 0) m.w14 = 8 * $urandom_range(0, 20);
      if ($urandom_range(0, 7) == 0) m.w4 = 32'h0000_0080;
      return m;
   endfunction

   task automatic record_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Track requests and check results on the same edge the block sees
   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (req_tvalid && req_tready) pending_match.push_back(predict_match(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_match.size() == 0) begin
               record_failure($sformatf("unexpected result match=%0b", rsp_tdata[0]));
            end else begin
               want = pending_match.pop_front();
               if (rsp_tdata[0] !== want)
                  record_failure($sformatf("match mismatch: expected %0b, got %0b",
                                           want, rsp_tdata[0]));
            end
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Call at a falling edge; returns at a falling edge with tvalid left high
   task automatic send_request(input md5cdc_pkg::md5cdc_msg_type m);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= m;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold off new requests until every expected result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_match.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_target(input logic [IDX_W-1:0] idx,
                               input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         md5cdc_pkg::REG_TARGET_A:           tgt_a = value;
         md5cdc_pkg::REG_TARGET_B_UNROTATED: tgt_b_pre = value;
         md5cdc_pkg::REG_TARGET_C:           tgt_c = value;
         md5cdc_pkg::REG_TARGET_D:           tgt_d = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_targets_from_candidate(input md5cdc_pkg::md5cdc_msg_type m);
      probe_words_type p;
      p = md5_probe(m);
      write_target(md5cdc_pkg::REG_TARGET_A, p.a61);
      write_target(md5cdc_pkg::REG_TARGET_B_UNROTATED, p.b_pre);
      write_target(md5cdc_pkg::REG_TARGET_C, p.c63);
      write_target(md5cdc_pkg::REG_TARGET_D, p.d62);
   endtask

   // Prepare targets the way host software would from a hex digest:
   // drop the initial values, then unwind the rotation and constant of step 64.
   task automatic load_targets_from_digest(input logic [127:0] dg);
      logic [31:0] ta, tc, td, diff, tb;
      ta   = digest_word(dg, 0) - md5cdc_pkg::IV_A;
      tc   = digest_word(dg, 2) - md5cdc_pkg::IV_C;
      td   = digest_word(dg, 3) - md5cdc_pkg::IV_D;
      diff = digest_word(dg, 1) - md5cdc_pkg::IV_B - tc;
      tb   = ((diff >> 21) | (diff << 11)) - STEP_K[63];
      write_target(md5cdc_pkg::REG_TARGET_A, ta);
      write_target(md5cdc_pkg::REG_TARGET_B_UNROTATED, tb);
      write_target(md5cdc_pkg::REG_TARGET_C, tc);
      write_target(md5cdc_pkg::REG_TARGET_D, td);
   endtask

   // Targets still at reset zero; push field extremes through
   task automatic test_reset_targets();
      md5cdc_pkg::md5cdc_msg_type m;
      m = '0;
      send_request(m);
      m = '1;
      send_request(m);
      m = '0;
      m.w0 = 32'hffff_ffff;
      m.w14 = 32'hffff_ffff;
      send_request(m);
      m = '1;
      m.w4 = 32'h0;
      send_request(m);
      wait_for_results();
   endtask

   // Real digests: "abc" and the empty string must both report a hit; a wrong length or pad must not
   task automatic test_known_digests();
      md5cdc_pkg::md5cdc_msg_type m;
      load_targets_from_digest(128'h900150983cd24fb0d6963f7d28e17f72);
      m = '0;
      m.w0  = 32'h8063_6261;
      m.w14 = 32'd24;
      send_request(m);
      m.w14 = 32'd32;
      send_request(m);
      wait_for_results();
      load_targets_from_digest(128'hd41d8cd98f00b204e9800998ecf8427e);
      m = '0;
      m.w0 = 32'h0000_0080;
      send_request(m);
      m.w0 = 32'h0;
      send_request(m);
      wait_for_results();
   endtask

   // Exact hit first, then break one compare at a time while the other three still agree
   task automatic test_single_compare_miss();
      md5cdc_pkg::md5cdc_msg_type m;
      probe_words_type            p;
      m = rand_candidate();
      p = md5_probe(m);
      load_targets_from_candidate(m);
      send_request(m);
      wait_for_results();
      write_target(md5cdc_pkg::REG_TARGET_A, p.a61 ^ 32'h8000_0000);
      send_request(m);
      wait_for_results();
      write_target(md5cdc_pkg::REG_TARGET_A, p.a61);
      write_target(md5cdc_pkg::REG_TARGET_B_UNROTATED, p.b_pre ^ 32'h0000_0001);
      send_request(m);
      wait_for_results();
      write_target(md5cdc_pkg::REG_TARGET_B_UNROTATED, p.b_pre);
      write_target(md5cdc_pkg::REG_TARGET_C, p.c63 ^ (32'h1 << $urandom_range(0, 31)));
      send_request(m);
      wait_for_results();
      write_target(md5cdc_pkg::REG_TARGET_C, p.c63);
      write_target(md5cdc_pkg::REG_TARGET_D, p.d62 ^ (32'h1 << $urandom_range(0, 31)));
      send_request(m);
      wait_for_results();
      // All-ones targets at the top extreme
      write_target(md5cdc_pkg::REG_TARGET_A, 32'hffff_ffff);
      write_target(md5cdc_pkg::REG_TARGET_B_UNROTATED, 32'hffff_ffff);
      write_target(md5cdc_pkg::REG_TARGET_C, 32'hffff_ffff);
      write_target(md5cdc_pkg::REG_TARGET_D, 32'hffff_ffff);
      m = '1;
      send_request(m);
      wait_for_results();
   endtask

   // Writes above the last register index must leave the targets alone
   task automatic test_ignored_index();
      md5cdc_pkg::md5cdc_msg_type m;
      m = rand_candidate();
      load_targets_from_candidate(m);
      write_target(IDX_W'(4), $urandom);
      write_target('1, $urandom);
      write_target(IDX_W'($urandom_range(5, 254)), $urandom);
      send_request(m);
      m.w1 = ~m.w1;
      send_request(m);
      wait_for_results();
   endtask

   // One random phase: aim targets at a seed candidate or at random words, then mix exact
   // hits, near misses and unrelated candidates.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input bit random_targets);
      md5cdc_pkg::md5cdc_msg_type seed_msg, m;
      logic [191:0]               flat;
      int                         pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      seed_msg = rand_candidate();
      if (random_targets) begin
         write_target(md5cdc_pkg::REG_TARGET_D, $urandom);
         write_target(md5cdc_pkg::REG_TARGET_C, $urandom);
         write_target(md5cdc_pkg::REG_TARGET_B_UNROTATED, $urandom);
         write_target(md5cdc_pkg::REG_TARGET_A, $urandom);
      end else begin
         load_targets_from_candidate(seed_msg);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            m = seed_msg;
         end else if (pick < 60) begin
            flat = seed_msg;
            repeat ($urandom_range(1, 3)) flat[$urandom_range(0, 191)] ^= 1'b1;
            m = flat;
         end else begin
            m = rand_candidate();
         end
         send_request(m);
      end
      wait_for_results();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      tgt_a         = 32'h0;
      tgt_b_pre     = 32'h0;
      tgt_c         = 32'h0;
      tgt_d         = 32'h0;
      fail_count    = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_targets();
      test_known_digests();
      test_single_compare_miss();
      test_ignored_index();

      // Cycle the idle patterns twice; one phase uses unrelated targets
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: test_random_traffic(0, 0, ph == 4);
            1: test_random_traffic(61, 0, 1'b0);
            2: test_random_traffic(0, 61, 1'b0);
            default: test_random_traffic(20, 20, 1'b0);
         endcase
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_match.size() != 0)
         $display("%0d results never arrived", pending_match.size());
      fail_count += pending_match.size();
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
